// File: sv/top_k_nearest_tracker_defines.svh
// ----------------------------------------------------------------------------
// Top-K nearest tracker assertion macros
// Shared concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef TOP_K_NEAREST_TRACKER_DEFINES_SVH
`define TOP_K_NEAREST_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKNT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tknt: same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TKNT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tknt: next-cycle assertion failed");

`endif

// File: sv/tknt_pkg.sv
// ----------------------------------------------------------------------------
// Top-K nearest tracker package
// Shared constants, request codes and cell control type.
// ----------------------------------------------------------------------------
package tknt_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF     = 32;
    localparam int DIST_BITS_DEF   = 16;

    localparam int REQ_W  = 2;
    localparam int RANK_W = 4;
    localparam int K_W    = 5;

    localparam logic [K_W-1:0] K_RESET = 5'd16;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef struct packed {
        logic upd;
        logic occupied;
    } t_cell_ctrl;

endpackage

// File: sv/tknt_if.sv
// ----------------------------------------------------------------------------
// Top-K nearest tracker channel interfaces
// Request, result and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface tknt_req_if
    import tknt_pkg::*;
#(
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int DIST_BITS = DIST_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [ID_BITS-1:0]   cand_id;
    logic [DIST_BITS-1:0] cand_distance;
    logic [RANK_W-1:0]    read_rank;

    modport source (output valid, req_type, cand_id, cand_distance, read_rank, input ready);
    modport sink   (input valid, req_type, cand_id, cand_distance, read_rank, output ready);
endinterface

interface tknt_res_if
    import tknt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int DIST_BITS   = DIST_BITS_DEF
);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic                 evicted_valid;
    logic [ID_BITS-1:0]   evicted_id;
    logic                 read_valid;
    logic [ID_BITS-1:0]   read_id;
    logic [DIST_BITS-1:0] read_distance;
    logic [CNT_W-1:0]     fill_count;

    modport source (output valid, accepted, evicted_valid, evicted_id, read_valid, read_id,
                    read_distance, fill_count, input ready);
    modport sink   (input valid, accepted, evicted_valid, evicted_id, read_valid, read_id,
                    read_distance, fill_count, output ready);
endinterface

interface tknt_cfg_if
    import tknt_pkg::*;
;
    logic           valid;
    logic           ready;
    logic [K_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: sv/top_k_nearest_tracker.sv
// ----------------------------------------------------------------------------
// Top-K nearest tracker
// Each result is registered and presented in the cycle after its request transfer.
// One request per cycle is accepted while the result register drains; the
// rate is set by the compare-and-shift pass along the cell row.
// Synchronous active-low reset empties the list and sets r_k to 16.
// ----------------------------------------------------------------------------
module top_k_nearest_tracker
    import tknt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int DIST_BITS   = DIST_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tknt_req_if.sink   i_req,
    tknt_cfg_if.sink   i_cfg,
    tknt_res_if.source o_res
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [K_W-1:0]       r_k;
    logic [CNT_W-1:0]     r_held;
    logic [CNT_W-1:0]     n_held;
    logic                 r_out_valid;
    logic                 r_acc;
    logic                 r_evict;
    logic [ID_BITS-1:0]   r_evict_id;
    logic                 r_rd_valid;
    logic [ID_BITS-1:0]   r_rd_id;
    logic [DIST_BITS-1:0] r_rd_dist;

    logic                 n_acc;
    logic                 n_evict;
    logic [ID_BITS-1:0]   n_evict_id;
    logic                 n_rd_valid;
    logic [ID_BITS-1:0]   n_rd_id;
    logic [DIST_BITS-1:0] n_rd_dist;

    logic                 w_in_fire;
    logic [CNT_W-1:0]     w_k_eff;
    logic                 w_room;
    logic                 w_any_before;

    logic [ID_BITS-1:0]   w_id        [MAX_ENTRIES];
    logic [DIST_BITS-1:0] w_dist      [MAX_ENTRIES];
    logic                 w_before    [MAX_ENTRIES];
    logic [ID_BITS-1:0]   w_prev_id   [MAX_ENTRIES];
    logic [DIST_BITS-1:0] w_prev_dist [MAX_ENTRIES];
    logic                 w_prev_bef  [MAX_ENTRIES];
    t_cell_ctrl           w_ctrl      [MAX_ENTRIES];

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_req.valid && i_req.ready;

    always_comb begin
        if (r_k == '0) begin
            w_k_eff = CNT_W'(1);
        end else if (int'(r_k) > MAX_ENTRIES) begin
            w_k_eff = CNT_W'(MAX_ENTRIES);
        end else begin
            w_k_eff = CNT_W'(r_k);
        end
    end

    assign w_room = r_held < w_k_eff;

    always_comb begin
        w_any_before = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_any_before = w_any_before || ((i < int'(r_held)) && w_before[i]);
        end
    end

    always_comb begin
        n_acc      = 1'b0;
        n_evict    = 1'b0;
        n_evict_id = '0;
        n_rd_valid = 1'b0;
        n_rd_id    = '0;
        n_rd_dist  = '0;
        n_held     = r_held;
        case (i_req.req_type)
            REQ_ADD: begin
                if (w_room) begin
                    n_acc  = 1'b1;
                    n_held = r_held + CNT_W'(1);
                end else if (r_held != '0 && w_any_before) begin
                    n_acc   = 1'b1;
                    n_evict = 1'b1;
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (int'(r_held) - 1 == i) begin
                            n_evict_id = n_evict_id | w_id[i];
                        end
                    end
                end
            end
            REQ_READ: begin
                if (int'(i_req.read_rank) < int'(r_held)) begin
                    n_rd_valid = 1'b1;
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (int'(i_req.read_rank) == i) begin
                            n_rd_id   = n_rd_id | w_id[i];
                            n_rd_dist = n_rd_dist | w_dist[i];
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                n_held = '0;
            end
            default: begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : gen_cell
            if (g == 0) begin : gen_head
                assign w_prev_id[g]   = '0;
                assign w_prev_dist[g] = '0;
                assign w_prev_bef[g]  = 1'b0;
            end else begin : gen_link
                assign w_prev_id[g]   = w_id[g-1];
                assign w_prev_dist[g] = w_dist[g-1];
                assign w_prev_bef[g]  = w_before[g-1];
            end

            assign w_ctrl[g].upd      = w_in_fire && n_acc;
            assign w_ctrl[g].occupied = g < int'(r_held);

            tknt_cell #(
                .ID_BITS   (ID_BITS),
                .DIST_BITS (DIST_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl[g]),
                .i_cand_id     (i_req.cand_id),
                .i_cand_dist   (i_req.cand_distance),
                .i_prev_id     (w_prev_id[g]),
                .i_prev_dist   (w_prev_dist[g]),
                .i_prev_before (w_prev_bef[g]),
                .o_id          (w_id[g]),
                .o_dist        (w_dist[g]),
                .o_before      (w_before[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= K_RESET;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_k <= i_cfg.data;
            end
            if (w_in_fire) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_acc      <= n_acc;
            r_evict    <= n_evict;
            r_evict_id <= n_evict_id;
            r_rd_valid <= n_rd_valid;
            r_rd_id    <= n_rd_id;
            r_rd_dist  <= n_rd_dist;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.accepted      = r_acc;
    assign o_res.evicted_valid = r_evict;
    assign o_res.evicted_id    = r_evict_id;
    assign o_res.read_valid    = r_rd_valid;
    assign o_res.read_id       = r_rd_id;
    assign o_res.read_distance = r_rd_dist;
    assign o_res.fill_count    = r_held;

endmodule

// File: sv/tknt_cell.sv
// ----------------------------------------------------------------------------
// Top-K nearest tracker cell
// One list slot: holds an id and a distance, and on an update either takes
// its better neighbour's entry, takes the candidate, or keeps its own.
// ----------------------------------------------------------------------------
module tknt_cell
    import tknt_pkg::*;
#(
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [ID_BITS-1:0]   i_cand_id,
    input  logic [DIST_BITS-1:0] i_cand_dist,
    input  logic [ID_BITS-1:0]   i_prev_id,
    input  logic [DIST_BITS-1:0] i_prev_dist,
    input  logic                 i_prev_before,
    output logic [ID_BITS-1:0]   o_id,
    output logic [DIST_BITS-1:0] o_dist,
    output logic                 o_before
);

    logic [ID_BITS-1:0]   r_id;
    logic [DIST_BITS-1:0] r_dist;
    logic [ID_BITS-1:0]   n_id;
    logic [DIST_BITS-1:0] n_dist;
    logic                 w_before;

    // An empty slot ranks behind any candidate.
    assign w_before = !i_ctrl.occupied || (i_cand_dist < r_dist);

    always_comb begin
        n_id   = r_id;
        n_dist = r_dist;
        if (i_ctrl.upd) begin
            if (i_prev_before) begin
                n_id   = i_prev_id;
                n_dist = i_prev_dist;
            end else if (w_before) begin
                n_id   = i_cand_id;
                n_dist = i_cand_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_dist <= n_dist;
    end

    assign o_id     = r_id;
    assign o_dist   = r_dist;
    assign o_before = w_before;

endmodule

// File: sv/tknt_checker.sv
// ----------------------------------------------------------------------------
// Top-K nearest tracker checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "top_k_nearest_tracker_defines.svh"

module tknt_checker
    import tknt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_res_valid,
    input logic                               i_res_ready,
    input logic                               i_accepted,
    input logic                               i_evicted_valid,
    input logic [ID_BITS-1:0]                 i_evicted_id,
    input logic                               i_read_valid,
    input logic [$clog2(MAX_ENTRIES + 1)-1:0] i_fill_count
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    `TKNT_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, i_res_valid, i_fill_count <= CNT_W'(MAX_ENTRIES))
    `TKNT_ASSERT_IMP(a_evict_needs_insert, i_clk, i_rst_n, i_res_valid && i_evicted_valid, i_accepted && (i_fill_count != '0))
    `TKNT_ASSERT_IMP(a_read_excl_add, i_clk, i_rst_n, i_res_valid && i_read_valid, !i_accepted && !i_evicted_valid && (i_fill_count != '0))
    `TKNT_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_fill_count) && $stable(i_evicted_id) && $stable(i_accepted))

endmodule

bind top_k_nearest_tracker tknt_checker #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_BITS     (ID_BITS)
) u_tknt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_accepted      (o_res.accepted),
    .i_evicted_valid (o_res.evicted_valid),
    .i_evicted_id    (o_res.evicted_id),
    .i_read_valid    (o_res.read_valid),
    .i_fill_count    (o_res.fill_count)
);

// File: sim/top_k_nearest_tracker_test.sv
// ----------------------------------------------------------------------------
// Top-K nearest tracker testbench
// Sends add, read, clear and unused requests through the request channel.
// A behavioural copy of the ranked list predicts the result of every request
// transfer, and each result transfer is checked field by field against it.
// The list size register is swept through its extremes, shrunk without a
// clear, and the result channel is held off long enough to stall requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module top_k_nearest_tracker_test;
    import tknt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PRINT_LIMIT     = 100;

    typedef struct packed {
        logic [REQ_W-1:0]         kind;
        logic [ID_BITS_DEF-1:0]   id;
        logic [DIST_BITS_DEF-1:0] distance;
        logic [RANK_W-1:0]        rank;
    } t_request;

    typedef struct packed {
        logic                     accepted;
        logic                     evicted_valid;
        logic [ID_BITS_DEF-1:0]   evicted_id;
        logic                     read_valid;
        logic [ID_BITS_DEF-1:0]   read_id;
        logic [DIST_BITS_DEF-1:0] read_distance;
        logic [K_W-1:0]           fill_count;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    tknt_req_if req_if ();
    tknt_cfg_if cfg_if ();
    tknt_res_if res_if ();

    top_k_nearest_tracker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    logic [ID_BITS_DEF-1:0]   ranked_ids   [MAX_ENTRIES_DEF];
    logic [DIST_BITS_DEF-1:0] ranked_dists [MAX_ENTRIES_DEF];
    int unsigned              ranked_count = 0;
    logic [K_W-1:0]           k_setting    = K_RESET;
    t_outcome                 pending_outcomes [$];

    int error_count         = 0;
    int result_count        = 0;
    int rx_mode             = 1;
    int hold_request_cycles = 0;
    int max_gap             = 3;
    int max_burst           = 8;
    int burst_left          = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("top_k_nearest_tracker_test: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t: mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                      result_count, name, got, want));
        end
    endtask

    function automatic void insert_entry(input int unsigned pos, input int unsigned last,
                                         input logic [ID_BITS_DEF-1:0] id,
                                         input logic [DIST_BITS_DEF-1:0] distance);
        for (int unsigned i = last; i > pos; i--) begin
            ranked_ids[i]   = ranked_ids[i - 1];
            ranked_dists[i] = ranked_dists[i - 1];
        end
        ranked_ids[pos]   = id;
        ranked_dists[pos] = distance;
    endfunction

    function automatic t_outcome rank_update_outcome(input t_request r);
        t_outcome    o;
        int unsigned keep;
        int unsigned pos;
        o = '0;
        case (r.kind)
            REQ_ADD: begin
                if (k_setting == 0) begin
                    keep = 1;
                end else if (k_setting > MAX_ENTRIES_DEF) begin
                    keep = MAX_ENTRIES_DEF;
                end else begin
                    keep = k_setting;
                end
                pos = 0;
                while (pos < ranked_count && ranked_dists[pos] <= r.distance) pos++;
                if (ranked_count < keep) begin
                    insert_entry(pos, ranked_count, r.id, r.distance);
                    ranked_count++;
                    o.accepted = 1'b1;
                end else if (ranked_count > 0 && r.distance < ranked_dists[ranked_count - 1]) begin
                    o.evicted_valid = 1'b1;
                    o.evicted_id    = ranked_ids[ranked_count - 1];
                    insert_entry(pos, ranked_count - 1, r.id, r.distance);
                    o.accepted = 1'b1;
                end
            end
            REQ_READ: begin
                if (r.rank < ranked_count) begin
                    o.read_valid    = 1'b1;
                    o.read_id       = ranked_ids[r.rank];
                    o.read_distance = ranked_dists[r.rank];
                end
            end
            REQ_CLEAR: begin
                ranked_count = 0;
            end
            default: begin
            end
        endcase
        o.fill_count = ranked_count[K_W-1:0];
        return o;
    endfunction

    always @(posedge i_clk) begin : outcome_check
        t_request req;
        t_outcome want;
        if (!i_rst_n) begin
            ranked_count = 0;
            k_setting    = K_RESET;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                k_setting = cfg_if.data;
            end
            if (req_if.valid && req_if.ready) begin
                req.kind     = req_if.req_type;
                req.id       = req_if.cand_id;
                req.distance = req_if.cand_distance;
                req.rank     = req_if.read_rank;
                pending_outcomes.push_back(rank_update_outcome(req));
            end
            if (res_if.valid && res_if.ready) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              result_count));
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("accepted", res_if.accepted, want.accepted);
                    check_field("evicted_valid", res_if.evicted_valid, want.evicted_valid);
                    check_field("evicted_id", res_if.evicted_id, want.evicted_id);
                    check_field("read_valid", res_if.read_valid, want.read_valid);
                    check_field("read_id", res_if.read_id, want.read_id);
                    check_field("read_distance", res_if.read_distance, want.read_distance);
                    check_field("fill_count", res_if.fill_count, want.fill_count);
                end
                result_count++;
            end
        end
    end

    initial begin : receiver
        int hold_count;
        int rx_phase;
        rx_phase = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request_cycles != 0) begin
                hold_count = hold_request_cycles;
                hold_request_cycles = 0;
                res_if.ready <= 1'b0;
                repeat (hold_count) @(negedge i_clk);
            end
            case (rx_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= 1'($urandom_range(0, 1));
                2: res_if.ready <= ($urandom_range(0, 3) == 0);
                default: res_if.ready <= ((rx_phase % 7) < 4);
            endcase
            rx_phase++;
        end
    end

    function automatic t_request make_request(input logic [REQ_W-1:0] kind,
                                              input logic [ID_BITS_DEF-1:0] id,
                                              input logic [DIST_BITS_DEF-1:0] distance,
                                              input logic [RANK_W-1:0] rank);
        t_request r;
        r.kind     = kind;
        r.id       = id;
        r.distance = distance;
        r.rank     = rank;
        return r;
    endfunction

    function automatic t_request random_request();
        int unsigned pick;
        int unsigned spread;
        t_request    r;
        pick   = $urandom_range(0, 99);
        spread = $urandom_range(0, 9);
        r.id   = $urandom;
        r.rank = $urandom_range(0, 15);
        if (spread < 5) begin
            r.distance = $urandom_range(0, 40);
        end else if (spread < 8) begin
            r.distance = $urandom_range(0, 16'hFFFF);
        end else if (spread == 8) begin
            r.distance = '1;
        end else begin
            r.distance = '0;
        end
        if (pick < 62) begin
            r.kind = REQ_ADD;
        end else if (pick < 95) begin
            r.kind = REQ_READ;
        end else if (pick < 97) begin
            r.kind = REQ_CLEAR;
        end else begin
            r.kind = REQ_NOP;
        end
        return r;
    endfunction

    task automatic send_request(input t_request r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, max_burst);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= r.kind;
        req_if.cand_id       <= r.id;
        req_if.cand_distance <= r.distance;
        req_if.read_rank     <= r.rank;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic settle_block();
        int waited;
        req_if.valid <= 1'b0;
        burst_left = 0;
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_outcomes.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
            pending_outcomes.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_k(input logic [K_W-1:0] value);
        settle_block();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        send_request(make_request(REQ_READ, 32'h0, 16'h0, 4'd0));
        send_request(make_request(REQ_READ, '1, '1, 4'd15));
        send_request(make_request(REQ_NOP, '1, '1, 4'd15));
        send_request(make_request(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF, 4'd0));
        send_request(make_request(REQ_ADD, 32'h0, 16'h0, 4'd15));
        send_request(make_request(REQ_ADD, 32'd1, 16'd100, 4'd0));
        send_request(make_request(REQ_ADD, 32'd2, 16'd100, 4'd0));
        send_request(make_request(REQ_ADD, 32'd3, 16'd100, 4'd0));
        send_request(make_request(REQ_ADD, 32'hA5A5_A5A5, 16'h0, 4'd0));
        for (int r = 0; r < 7; r++) begin
            send_request(make_request(REQ_READ, '0, '0, r[RANK_W-1:0]));
        end
        send_request(make_request(REQ_READ, '0, '0, 4'd15));
        send_request(make_request(REQ_CLEAR, '1, '1, 4'd15));
        send_request(make_request(REQ_READ, '0, '0, 4'd0));
        send_request(make_request(REQ_NOP, '0, '0, 4'd0));
        send_request(make_request(REQ_ADD, 32'h5A5A_5A5A, 16'd1, 4'd0));
        send_request(make_request(REQ_READ, '0, '0, 4'd0));
    endtask

    task automatic test_register_extremes();
        logic [K_W-1:0] settings [4] = '{5'd1, 5'd0, 5'd31, 5'd17};
        foreach (settings[s]) begin
            write_k(settings[s]);
            send_request(make_request(REQ_CLEAR, $urandom, '0, '0));
            repeat (20) begin
                send_request(make_request(REQ_ADD, $urandom, $urandom_range(0, 30),
                                          $urandom_range(0, 15)));
            end
            send_request(make_request(REQ_READ, $urandom, '0, 4'd0));
            send_request(make_request(REQ_READ, $urandom, '0, 4'd15));
        end
    endtask

    task automatic test_shrink_without_clear();
        write_k(5'd16);
        send_request(make_request(REQ_CLEAR, '0, '0, '0));
        for (int n = 0; n < 16; n++) begin
            send_request(make_request(REQ_ADD, $urandom, 16'(100 + n), '0));
        end
        write_k(5'd3);
        send_request(make_request(REQ_ADD, $urandom, 16'd50, '0));
        send_request(make_request(REQ_ADD, $urandom, 16'd200, '0));
        send_request(make_request(REQ_ADD, $urandom, 16'd114, '0));
        send_request(make_request(REQ_READ, '0, '0, 4'd15));
        send_request(make_request(REQ_READ, '0, '0, 4'd0));
        write_k(5'd16);
        send_request(make_request(REQ_ADD, $urandom, 16'd10, '0));
        send_request(make_request(REQ_READ, '0, '0, 4'd15));
        send_request(make_request(REQ_CLEAR, '0, '0, '0));
    endtask

    task automatic test_output_backpressure();
        settle_block();
        rx_mode   = 0;
        max_gap   = 0;
        max_burst = 1000;
        hold_request_cycles = 60;
        repeat (80) send_request(random_request());
    endtask

    task automatic test_random_traffic();
        logic [K_W-1:0] plan [10] = '{5'd16, 5'd7, 5'd1, 5'd0, 5'd12,
                                      5'd31, 5'd2, 5'd17, 5'd5, 5'd16};
        foreach (plan[p]) begin
            write_k(plan[p]);
            if ($urandom_range(0, 1) == 1) begin
                send_request(make_request(REQ_CLEAR, $urandom, '0, '0));
            end
            if (p == 0) begin
                rx_mode = 0;
                max_gap = 0;
            end else begin
                rx_mode = $urandom_range(0, 3);
                max_gap = (p % 3 == 0) ? 2 : ((p % 3 == 1) ? 6 : 12);
            end
            max_burst = $urandom_range(1, 24);
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.req_type      = '0;
        req_if.cand_id       = '0;
        req_if.cand_distance = '0;
        req_if.read_rank     = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_register_extremes();
        test_shrink_without_clear();
        test_output_backpressure();
        test_random_traffic();
        settle_block();

        if (error_count == 0) begin
            $display("top_k_nearest_tracker_test: done, clean");
        end else begin
            $display("top_k_nearest_tracker_test: done, errors");
        end
        $finish;
    end

endmodule
